// ----- hw/rtl/fbpa_pkg.sv -----
`default_nettype none

package fbpa_pkg;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int QUOT_W  = 7;

    // search unit looks at this many map bits per cycle
    localparam int SCAN_W  = 8;
    localparam int SCAN_LG = 3;

    // default pool capacity
    localparam int MAX_BLOCKS_DEF = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    // configuration reset values
    localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd0;
    localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE  = 16'd8;
    localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT = 7'd64;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // request word
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
    } req_word_t;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  granted_address;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
    } rsp_word_t;

    // status from the free-block search
    typedef struct packed {
        logic done;
        logic found;
    } search_stat_t;

    // status from the offset divider
    typedef struct packed {
        logic done;
        logic exact;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fbpa_search.sv -----
`default_nettype none

module fbpa_search
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MAX_BLOCKS-1:0] used_bits,
    input  wire logic [COUNT_W-1:0]   live_count,
    output search_stat_t              stat,
    output logic [IDX_W-1:0]          index
);

    localparam int NCHUNK = (MAX_BLOCKS + SCAN_W - 1) / SCAN_W;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int GI_W   = CH_W + SCAN_LG;
    localparam int CMP_W  = (GI_W > COUNT_W) ? GI_W : COUNT_W;

    logic [NCHUNK*SCAN_W-1:0] padded;
    logic [SCAN_W-1:0]        chunk_bits;
    logic [SCAN_W-1:0]        cand;
    logic                     pick_found;
    logic [SCAN_LG-1:0]       pick_pos;
    logic [GI_W-1:0]          pick_gi;

    logic [CH_W-1:0]  chunk_reg, chunk_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] index_reg, index_next;

    // map padded to whole chunks, padding reads as taken
    for (genvar g = 0; g < NCHUNK * SCAN_W; g++)
    begin : g_pad
        if (g < MAX_BLOCKS)
        begin : g_live
            assign padded[g] = used_bits[g];
        end
        else
        begin : g_fill
            assign padded[g] = 1'b1;
        end
    end

    assign chunk_bits = padded[chunk_reg*SCAN_W +: SCAN_W];

    // free slots of this chunk that lie below the live count
    always_comb
    begin
        logic [GI_W-1:0] gi;
        for (int j = 0; j < SCAN_W; j++)
        begin
            gi      = {chunk_reg, SCAN_LG'(j)};
            cand[j] = !chunk_bits[j] && (CMP_W'(gi) < CMP_W'(live_count));
        end
    end

    // lowest free slot in the chunk
    always_comb
    begin
        pick_found = 1'b0;
        pick_pos   = '0;
        for (int j = SCAN_W - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                pick_found = 1'b1;
                pick_pos   = SCAN_LG'(j);
            end
        end
    end

    assign pick_gi = {chunk_reg, pick_pos};

    // chunk walker
    always_comb
    begin
        chunk_next = chunk_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        index_next = index_reg;
        if (start)
        begin
            chunk_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pick_found)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b1;
                index_next = pick_gi[IDX_W-1:0];
            end
            else if (chunk_reg == CH_W'(NCHUNK - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b0;
            end
            else
            begin
                chunk_next = chunk_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_reg <= chunk_next;
        found_reg <= found_next;
        index_reg <= index_next;
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign index      = index_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_div.sv -----
`default_nettype none

module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int DVD_W = SIZE_W + COUNT_W
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [SIZE_W-1:0] divisor,
    output div_stat_t              stat,
    output logic [QUOT_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DVD_W-1:0]  trial;
    logic              fits;
    logic [DVD_W-1:0]  rem_after;

    logic [DVD_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              exact_reg, exact_next;

    // shared compare and subtract against the shifted divisor
    assign trial     = DVD_W'(divisor) << step_reg;
    assign fits      = rem_reg >= trial;
    assign rem_after = fits ? rem_reg - trial : rem_reg;

    // one quotient bit per cycle, most significant first
    always_comb
    begin
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        exact_next = exact_reg;
        if (start)
        begin
            rem_next  = dividend;
            quot_next = '0;
            step_next = STEP_W'(QUOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_after;
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                exact_next = (rem_after == '0);
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        exact_reg <= exact_next;
    end

    assign stat.done  = done_reg;
    assign stat.exact = exact_reg;
    assign quotient   = quot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator.
// Request channel (req_valid/req_ready/req): one word per request, mode
// allocate or free plus the address to free. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one word per request, in order, with
// status, granted address and the free and used counts after the request.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// pool base, 1 block size, 2 block count; any of these writes rebuilds the
// pool with every block free. Other indexes are taken and ignored. A waiting
// register write goes ahead of a request offered in the same cycle.
// One request is in flight at a time; req_ready is high only while the
// sequencer is idle. Allocate starts the free-block search, which walks the
// map in 8-block chunks, then multiplies the block index by the block size
// and adds the pool base; it goes straight to the response when the pool is
// already empty. Free multiplies block size by live block count to check the
// range, then divides the offset by the block size in the 7-step shared
// subtract unit; an address outside the pool skips the division. The
// sequencer is back in idle as rsp_valid rises. The finished word sits in an
// output register, so the next request is taken while the receiver stalls;
// a further result waits in the sequencer until that register empties.
// Reset: pool base 0, block size 8, block count 64, all blocks free.
`default_nettype none

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_word_t            req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_word_t                 rsp,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int OP_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
    localparam int PROD_W = SIZE_W + OP_W;
    localparam int CAP_I  = (MAX_BLOCKS > 127) ? 127 : MAX_BLOCKS;
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_I);
    localparam logic [COUNT_W-1:0] RST_FREE =
        (RST_BLOCK_COUNT > CAP) ? CAP : RST_BLOCK_COUNT;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     pool_base_reg, pool_base_next;
    logic [SIZE_W-1:0]     block_size_reg, block_size_next;
    logic [COUNT_W-1:0]    block_count_reg, block_count_next;
    logic [MAX_BLOCKS-1:0] used_bits_reg, used_bits_next;
    logic [COUNT_W-1:0]    free_total_reg, free_total_next;
    logic [COUNT_W-1:0]    used_total_reg, used_total_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_word_t             rsp_reg, rsp_next;
    logic                  mode_reg, mode_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;

    logic [COUNT_W-1:0]      live_n;
    logic [OP_W-1:0]         mul_op;
    logic [ADDR_W:0]         diff;
    logic                    range_ok;
    logic                    srch_start;
    search_stat_t            srch_stat;
    logic [IDX_W-1:0]        srch_index;
    logic                    div_start;
    div_stat_t               div_stat;
    logic [QUOT_W-1:0]       quotient;
    logic [IDX_W+QUOT_W-1:0] q_wide;
    logic [IDX_W-1:0]        q_idx;

    function automatic logic [COUNT_W-1:0] cap_count(input logic [COUNT_W-1:0] c);
        return (c > CAP) ? CAP : c;
    endfunction

    assign live_n = cap_count(block_count_reg);

    // shared multiplier operand: block index on allocate, live count on free
    assign mul_op = (mode_reg == MODE_ALLOC) ? OP_W'(idx_reg) : OP_W'(live_n);

    // offset from pool base; must be non-negative and below size times count
    assign diff     = {1'b0, addr_reg} - {1'b0, pool_base_reg};
    assign range_ok = !diff[ADDR_W] && (block_size_reg != '0)
                      && (diff[ADDR_W-1:0] < ADDR_W'(prod_reg));

    // quotient to block index
    assign q_wide = {{IDX_W{1'b0}}, quotient};
    assign q_idx  = q_wide[IDX_W-1:0];

    fbpa_search #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (srch_start),
        .used_bits  (used_bits_reg),
        .live_count (live_n),
        .stat       (srch_stat),
        .index      (srch_index)
    );

    fbpa_div #(
        .DVD_W (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff[PROD_W-1:0]),
        .divisor  (block_size_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // a pending register write is taken before any request
    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    // sequencer and pool state
    always_comb
    begin
        logic               rebuild;
        logic [COUNT_W-1:0] new_count;

        state_next       = state_reg;
        pool_base_next   = pool_base_reg;
        block_size_next  = block_size_reg;
        block_count_next = block_count_reg;
        used_bits_next   = used_bits_reg;
        free_total_next  = free_total_reg;
        used_total_next  = used_total_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        prod_next        = prod_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        srch_start       = 1'b0;
        div_start        = 1'b0;
        rebuild          = 1'b0;
        new_count        = block_count_reg;

        // output word taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    mode_next = req.mode;
                    addr_next = req.address;
                    if (req.mode == MODE_FREE)
                    begin
                        state_next = S_MUL;
                    end
                    else if (free_total_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        srch_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (srch_stat.done)
                begin
                    if (srch_stat.found)
                    begin
                        idx_next   = srch_index;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_status_next = ST_EMPTY;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(block_size_reg) * PROD_W'(mul_op);
                state_next = (mode_reg == MODE_ALLOC) ? S_ADD : S_CHECK;
            end
            S_ADD:
            begin
                res_addr_next           = pool_base_reg + ADDR_W'(prod_reg);
                res_status_next         = ST_OK;
                used_bits_next[idx_reg] = 1'b1;
                free_total_next         = free_total_reg - 1'b1;
                used_total_next         = used_total_reg + 1'b1;
                state_next              = S_DONE;
            end
            S_CHECK:
            begin
                if (range_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_status_next = ST_INVALID;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_addr_next = '0;
                    if (div_stat.exact && used_bits_reg[q_idx])
                    begin
                        used_bits_next[q_idx] = 1'b0;
                        free_total_next       = free_total_reg + 1'b1;
                        used_total_next       = used_total_reg - 1'b1;
                        res_status_next       = ST_OK;
                    end
                    else
                    begin
                        res_status_next = ST_INVALID;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status          = res_status_reg;
                    rsp_next.granted_address = res_addr_reg;
                    rsp_next.free_count      = free_total_reg;
                    rsp_next.used_count      = used_total_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writes to pool base, block size or block count rebuild the pool
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_BASE:
                begin
                    pool_base_next = cfg_data;
                    rebuild        = 1'b1;
                end
                CFG_BLOCK_SIZE:
                begin
                    block_size_next = cfg_data[SIZE_W-1:0];
                    rebuild         = 1'b1;
                end
                CFG_BLOCK_COUNT:
                begin
                    block_count_next = cfg_data[COUNT_W-1:0];
                    new_count        = cfg_data[COUNT_W-1:0];
                    rebuild          = 1'b1;
                end
                default:
                begin
                    rebuild = 1'b0;
                end
            endcase
            if (rebuild)
            begin
                used_bits_next  = '0;
                free_total_next = cap_count(new_count);
                used_total_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pool_base_reg   <= RST_POOL_BASE;
            block_size_reg  <= RST_BLOCK_SIZE;
            block_count_reg <= RST_BLOCK_COUNT;
            used_bits_reg   <= '0;
            free_total_reg  <= RST_FREE;
            used_total_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pool_base_reg   <= pool_base_next;
            block_size_reg  <= block_size_next;
            block_count_reg <= block_count_next;
            used_bits_reg   <= used_bits_next;
            free_total_reg  <= free_total_next;
            used_total_reg  <= used_total_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // free and used always add up to the live block count
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (8'(free_total_reg) + 8'(used_total_reg)) == 8'(live_n))
        else $error("free and used counts do not match block count");

    // an accepted request always leaves idle
    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // a new response word only comes out of the done state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");

    // empty status only when no block is free
    a_empty_means_none: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_EMPTY)) |-> (rsp_reg.free_count == '0))
        else $error("empty status with free blocks left");

    // divider finishes only while the sequencer waits on it
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

endmodule

`default_nettype wire
